>>> src/assert_macros.svh
// Assertion macros shared by the row unfilter RTL.
// Included by the modules that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PRU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define PRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pru_pkg.sv
// Shared types, codes and helper functions of the row unfilter.
// Used by every module of the block; depends on nothing.
package pru_pkg;

    localparam int DEFAULT_MAX_ROW_BYTES = 16384;

    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int ERR_W       = 2;
    localparam int FILTER_W    = 3;
    localparam int SLOT_W      = 3;
    localparam int ROW_BYTES_W = 15;
    localparam int BPP_W       = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;
    localparam int HIST_DEPTH  = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_PIXEL = 2'd1;

    // input word kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PASS = 2'd2;

    // result error codes
    localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FILTER  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OUTSIDE = 2'd2;

    // filter types
    localparam logic [FILTER_W-1:0] FILT_NONE  = 3'd0;
    localparam logic [FILTER_W-1:0] FILT_SUB   = 3'd1;
    localparam logic [FILTER_W-1:0] FILT_UP    = 3'd2;
    localparam logic [FILTER_W-1:0] FILT_AVG   = 3'd3;
    localparam logic [FILTER_W-1:0] FILT_PAETH = 3'd4;
    localparam logic [BYTE_W-1:0]   FILTER_LIMIT = 8'd5;

    localparam logic [BPP_W-1:0] MAX_BPP = 4'd8;

    // reciprocals 2^18/k rounded up, exact for 15-bit dividends
    localparam logic [16:0] RECIP_3 = 17'd87382;
    localparam logic [16:0] RECIP_5 = 17'd52429;
    localparam logic [16:0] RECIP_6 = 17'd43691;
    localparam logic [16:0] RECIP_7 = 17'd37450;

    // one decoded word handed from the sequencer to the predictor stage
    typedef struct packed {
        logic                is_data;
        logic [ERR_W-1:0]    error;
        logic [BYTE_W-1:0]   data_byte;
        logic [FILTER_W-1:0] filter;
        logic [SLOT_W-1:0]   slot;
        logic                left_ok;
        logic                first_row;
        logic                last;
    } pru_cmd_t;

    // remainder by a small constant through a reciprocal multiply
    function automatic logic [SLOT_W-1:0] recip_mod(input logic [14:0] v,
                                                    input logic [16:0] m,
                                                    input logic [3:0] k);
        logic [31:0] prod;
        logic [13:0] q;
        logic [29:0] qk;
        logic [14:0] r;
        prod = {17'd0, v} * {15'd0, m};
        q    = prod[31:18];
        qk   = {1'b0, q} * {11'd0, k};
        r    = v - qk[14:0];
        return r[SLOT_W-1:0];
    endfunction

    // v mod k for k in 1..8
    function automatic logic [SLOT_W-1:0] residue_small(input logic [14:0] v,
                                                        input logic [BPP_W-1:0] k);
        logic [SLOT_W-1:0] r;
        case (k)
            4'd2:    r = {2'b00, v[0]};
            4'd3:    r = recip_mod(v, RECIP_3, 4'd3);
            4'd4:    r = {1'b0, v[1:0]};
            4'd5:    r = recip_mod(v, RECIP_5, 4'd5);
            4'd6:    r = recip_mod(v, RECIP_6, 4'd6);
            4'd7:    r = recip_mod(v, RECIP_7, 4'd7);
            4'd8:    r = v[2:0];
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

>>> src/pru_if.sv
// Stream interfaces of the row unfilter: filtered input words and
// reconstructed output words. Depends on pru_pkg for field widths.
interface pru_in_if
    import pru_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface pru_out_if
    import pru_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel_byte;
    logic              last_of_row;
    logic [ERR_W-1:0]  error;

    modport source (output valid, output pixel_byte, output last_of_row, output error,
                    input ready);
    modport sink   (input valid, input pixel_byte, input last_of_row, input error,
                    output ready);
endinterface

>>> src/pru_row_mem.sv
// Previous-row byte store: one write port, one registered read port.
// A read of the address written in the same cycle returns the new byte.
module pru_row_mem
    import pru_pkg::*;
#(
    parameter int DEPTH = DEFAULT_MAX_ROW_BYTES,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // write the reconstructed byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read with write-first bypass on an address match
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/pru_sequencer.sv
// Row sequencer: configuration registers, row position and pixel slot
// tracking, previous-row read issue. Depends on pru_pkg.
`include "assert_macros.svh"

module pru_sequencer
    import pru_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEFAULT_MAX_ROW_BYTES,
    parameter int AW            = $clog2(MAX_ROW_BYTES)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   acc,
    input  logic [KIND_W-1:0]      kind,
    input  logic [BYTE_W-1:0]      data_byte,
    output logic                   load,
    output pru_cmd_t               cmd,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr
);

    localparam int PW = $clog2(MAX_ROW_BYTES + 1);
    localparam int RW = (PW > 16) ? PW : 16;

    logic [ROW_BYTES_W-1:0] row_bytes_reg;
    logic [BPP_W-1:0]       bpp_reg;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [FILTER_W-1:0]    filter_reg, filter_next;
    logic                   first_row_reg, first_row_next;
    logic                   row_active_reg, row_active_next;
    logic [SLOT_W-1:0]      cnt_reg [HIST_DEPTH];
    logic [SLOT_W-1:0]      cnt_next [HIST_DEPTH];

    logic [RW-1:0]     rb_ext, rb_eff, rbm1, pos_ext, i_ext, i_inc;
    logic [BPP_W-1:0]  bpp_eff, bpp_m1;
    logic              clamped, is_last;
    logic [SLOT_W-1:0] slot;
    logic [AW-1:0]     i_addr;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= 15'd1;
            bpp_reg       <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_BYTES:       row_bytes_reg <= cfg_data;
                REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[BPP_W-1:0];
                default:             ;
            endcase
        end
    end

    // clamp registers and locate the byte inside the row
    always_comb
    begin
        rb_ext = RW'(row_bytes_reg);
        if (row_bytes_reg == '0)
        begin
            rb_eff = RW'(1);
        end
        else if (rb_ext > RW'(MAX_ROW_BYTES))
        begin
            rb_eff = RW'(MAX_ROW_BYTES);
        end
        else
        begin
            rb_eff = rb_ext;
        end
        if (bpp_reg == '0)
        begin
            bpp_eff = 4'd1;
        end
        else if (bpp_reg > MAX_BPP)
        begin
            bpp_eff = MAX_BPP;
        end
        else
        begin
            bpp_eff = bpp_reg;
        end
        bpp_m1  = bpp_eff - 4'd1;
        rbm1    = rb_eff - RW'(1);
        pos_ext = RW'(pos_reg);
        clamped = (pos_ext >= rb_eff);
        i_ext   = clamped ? rbm1 : pos_ext;
        i_inc   = i_ext + RW'(1);
        is_last = (i_inc >= rb_eff);
        i_addr  = i_ext[AW-1:0];
        slot    = clamped ? residue_small(rbm1[14:0], bpp_eff) : cnt_reg[bpp_m1[SLOT_W-1:0]];
    end

    // decode the accepted word and advance row state
    always_comb
    begin
        pos_next        = pos_reg;
        filter_next     = filter_reg;
        first_row_next  = first_row_reg;
        row_active_next = row_active_reg;
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            cnt_next[k] = cnt_reg[k];
        end
        load          = 1'b0;
        rd_en         = 1'b0;
        cmd           = '0;
        cmd.data_byte = data_byte;
        cmd.error     = ERR_NONE;
        if (acc)
        begin
            case (kind)
                KIND_DATA:
                begin
                    load = 1'b1;
                    if (!row_active_reg)
                    begin
                        cmd.error = ERR_OUTSIDE;
                    end
                    else
                    begin
                        rd_en         = 1'b1;
                        cmd.is_data   = 1'b1;
                        cmd.filter    = filter_reg;
                        cmd.slot      = slot;
                        cmd.left_ok   = (i_ext >= RW'(bpp_eff));
                        cmd.first_row = first_row_reg;
                        cmd.last      = is_last;
                        if (is_last)
                        begin
                            row_active_next = 1'b0;
                            first_row_next  = 1'b0;
                            pos_next        = '0;
                            for (int k = 0; k < HIST_DEPTH; k++)
                            begin
                                cnt_next[k] = '0;
                            end
                        end
                        else
                        begin
                            pos_next = i_addr + AW'(1);
                            for (int k = 0; k < HIST_DEPTH; k++)
                            begin
                                cnt_next[k] = (cnt_reg[k] == SLOT_W'(k)) ? '0
                                                                        : cnt_reg[k] + 3'd1;
                            end
                        end
                    end
                end
                KIND_ROW, KIND_PASS:
                begin
                    if (kind == KIND_PASS)
                    begin
                        first_row_next = 1'b1;
                    end
                    if (data_byte >= FILTER_LIMIT)
                    begin
                        row_active_next = 1'b0;
                        load            = 1'b1;
                        cmd.error       = ERR_FILTER;
                    end
                    else
                    begin
                        filter_next     = data_byte[FILTER_W-1:0];
                        pos_next        = '0;
                        row_active_next = 1'b1;
                        for (int k = 0; k < HIST_DEPTH; k++)
                        begin
                            cnt_next[k] = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // hold row state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            filter_reg     <= FILT_NONE;
            first_row_reg  <= 1'b1;
            row_active_reg <= 1'b0;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            pos_reg        <= pos_next;
            filter_reg     <= filter_next;
            first_row_reg  <= first_row_next;
            row_active_reg <= row_active_next;
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    assign rd_addr = i_addr;

    `PRU_ASSERT_NEXT(a_row_closes, clk, rst_n, load && cmd.is_data && cmd.last, !row_active_reg, "row still open after its last byte")
    `PRU_ASSERT_IMPL(a_read_in_row, clk, rst_n, rd_en, row_active_reg && load && cmd.is_data, "row read issued outside an open row")

endmodule

>>> src/pru_predictor.sv
// Predictor stage and output register: left/up-left history, filter
// arithmetic, previous-row write-back. Depends on pru_pkg and pru_if.
`include "assert_macros.svh"

module pru_predictor
    import pru_pkg::*;
#(
    parameter int AW = $clog2(DEFAULT_MAX_ROW_BYTES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  pru_cmd_t          cmd,
    input  logic [AW-1:0]     addr,
    input  logic [BYTE_W-1:0] rd_data,
    output logic              s1_ready,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    pru_out_if.source         pixels
);

    logic              s1_valid_reg, s1_valid_next;
    pru_cmd_t          s1_cmd_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_pixel_reg;
    logic              out_last_reg;
    logic [ERR_W-1:0]  out_err_reg;
    logic [BYTE_W-1:0] left_hist_reg [HIST_DEPTH];
    logic [BYTE_W-1:0] upleft_hist_reg [HIST_DEPTH];

    logic              out_free, s1_fire;
    logic [BYTE_W-1:0] left, up, upleft, pred, val, pa, pb;
    logic [8:0]        avg_sum;
    logic [9:0]        ab_sum, c_twice, pc, pa_w, pb_w;

    assign out_free = !out_valid_reg || pixels.ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s1_ready = !s1_valid_reg || out_free;

    // form the prediction terms and reconstruct the byte
    always_comb
    begin
        left    = s1_cmd_reg.left_ok ? left_hist_reg[s1_cmd_reg.slot] : '0;
        up      = s1_cmd_reg.first_row ? '0 : rd_data;
        upleft  = (s1_cmd_reg.left_ok && !s1_cmd_reg.first_row)
                  ? upleft_hist_reg[s1_cmd_reg.slot] : '0;
        avg_sum = {1'b0, left} + {1'b0, up};
        pa      = (up > upleft) ? up - upleft : upleft - up;
        pb      = (left > upleft) ? left - upleft : upleft - left;
        ab_sum  = {2'b00, left} + {2'b00, up};
        c_twice = {1'b0, upleft, 1'b0};
        pc      = (ab_sum > c_twice) ? ab_sum - c_twice : c_twice - ab_sum;
        pa_w    = {2'b00, pa};
        pb_w    = {2'b00, pb};
        case (s1_cmd_reg.filter)
            FILT_SUB:   pred = left;
            FILT_UP:    pred = up;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH:
            begin
                if ((pa_w <= pb_w) && (pa_w <= pc))
                begin
                    pred = left;
                end
                else if (pb_w <= pc)
                begin
                    pred = up;
                end
                else
                begin
                    pred = upleft;
                end
            end
            default:    pred = '0;
        endcase
        val = s1_cmd_reg.data_byte + pred;
    end

    assign wr_en   = s1_fire && s1_cmd_reg.is_data;
    assign wr_addr = s1_addr_reg;
    assign wr_data = val;

    // advance the stage and output valid flags
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixels.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the decoded word
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_cmd_reg  <= cmd;
            s1_addr_reg <= addr;
        end
    end

    // load the output word
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            if (s1_cmd_reg.is_data)
            begin
                out_pixel_reg <= val;
                out_last_reg  <= s1_cmd_reg.last;
                out_err_reg   <= ERR_NONE;
            end
            else
            begin
                out_pixel_reg <= '0;
                out_last_reg  <= 1'b0;
                out_err_reg   <= s1_cmd_reg.error;
            end
        end
    end

    // update left and up-left history at the byte's slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                left_hist_reg[k]   <= '0;
                upleft_hist_reg[k] <= '0;
            end
        end
        else if (wr_en)
        begin
            left_hist_reg[s1_cmd_reg.slot]   <= val;
            upleft_hist_reg[s1_cmd_reg.slot] <= up;
        end
    end

    assign pixels.valid       = out_valid_reg;
    assign pixels.pixel_byte  = out_pixel_reg;
    assign pixels.last_of_row = out_last_reg;
    assign pixels.error       = out_err_reg;

    `PRU_ASSERT_IMPL(a_no_overrun, clk, rst_n, s1_valid_reg && !out_free, !load, "stage loaded while stalled")
    `PRU_ASSERT_IMPL(a_error_clean, clk, rst_n, out_valid_reg && (out_err_reg != ERR_NONE), (out_pixel_reg == 8'd0) && !out_last_reg, "error word carries pixel data")

endmodule

>>> src/png_row_unfilter_top.sv
// PNG row unfilter: sequencer, previous-row memory and predictor stage.
// Depends on pru_pkg, pru_if and the three submodules.
//
// Usage:
//   filtered carries inflated bytes: kind 1 or 2 opens a row with its filter
//   type (2 also marks the first row of a pass), kind 0 is a data byte.
//   pixels returns one word per data byte (reconstructed, last_of_row on the
//   row's final byte) and one error word per bad filter type or per data
//   byte outside an open row. Filter bytes that are valid give no word.
//   cfg_we/cfg_index/cfg_data write row_bytes (index 0) and bytes_per_pixel
//   (index 1); write them only while no word is in flight.
// Timing:
//   An accepted word passes the predictor stage register and the output
//   register before it shows on pixels. One word per cycle is sustained
//   while pixels does not stall; the previous-row memory is read and
//   written once per byte, a same-address read picks up the new byte.
// Reset and stall:
//   Reset clears row state and history and sets both registers to 1; the
//   row memory is not cleared and needs no sweep. When pixels stalls, the
//   output register holds; a loaded predictor stage holds and drops filtered.ready.
module png_row_unfilter_top
    import pru_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEFAULT_MAX_ROW_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pru_in_if.sink                 filtered,
    pru_out_if.source              pixels
);

    localparam int AW = $clog2(MAX_ROW_BYTES);

    logic              acc, load, rd_en, s1_ready, wr_en;
    pru_cmd_t          cmd;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [BYTE_W-1:0] rd_data, wr_data;

    assign acc            = filtered.valid && filtered.ready;
    assign filtered.ready = s1_ready;

    pru_sequencer #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .AW            (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (acc),
        .kind      (filtered.kind),
        .data_byte (filtered.data_byte),
        .load      (load),
        .cmd       (cmd),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    pru_row_mem #(
        .DEPTH (MAX_ROW_BYTES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pru_predictor #(
        .AW (AW)
    ) u_pred (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .cmd      (cmd),
        .addr     (rd_addr),
        .rd_data  (rd_data),
        .s1_ready (s1_ready),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .pixels   (pixels)
    );

endmodule

>>> sim/png_row_unfilter_checker.sv
// Result checker for the PNG row unfilter: predicts every output word from
// the accepted input words and register writes, and compares in order.
// Depends on pru_pkg and the stream interfaces in pru_if.
module png_row_unfilter_checker
    import pru_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEFAULT_MAX_ROW_BYTES
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    pru_in_if                      filtered,
    pru_out_if                     pixels,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic              last;
        logic [ERR_W-1:0]  error;
    } pixel_word_t;

    pixel_word_t       pending_pixels[$];

    // reconstruction state
    logic [BYTE_W-1:0]   prior_row [MAX_ROW_BYTES];
    logic [BYTE_W-1:0]   left_hist [HIST_DEPTH];
    logic [BYTE_W-1:0]   above_left_hist [HIST_DEPTH];
    int                  row_pos;
    logic [FILTER_W-1:0] row_filter;
    bit                  pass_first_row;
    bit                  row_open;
    int                  row_len_reg;
    int                  pixel_dist_reg;
    int                  fail_count;

    // pick the neighbor closest to left + up - upleft, ties toward left, then up
    function automatic logic [BYTE_W-1:0] paeth_choice(input logic [BYTE_W-1:0] a,
                                                       input logic [BYTE_W-1:0] b,
                                                       input logic [BYTE_W-1:0] c);
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da = est - int'(a);
        db = est - int'(b);
        dc = est - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc)
            return a;
        if (db <= dc)
            return b;
        return c;
    endfunction

    // work out the word, if any, that one input word causes
    task automatic reconstruct(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
        int                len;
        int                stride;
        int                i;
        int                slot;
        logic [BYTE_W-1:0] left;
        logic [BYTE_W-1:0] up;
        logic [BYTE_W-1:0] upleft;
        logic [BYTE_W-1:0] base;
        logic [BYTE_W-1:0] val;
        pixel_word_t       w;
        if (k == KIND_ROW || k == KIND_PASS) begin
            if (k == KIND_PASS)
                pass_first_row = 1'b1;
            if (b >= FILTER_LIMIT) begin
                row_open = 1'b0;
                w.pixel = '0;
                w.last = 1'b0;
                w.error = ERR_FILTER;
                pending_pixels.push_back(w);
            end else begin
                row_filter = b[FILTER_W-1:0];
                row_pos = 0;
                row_open = 1'b1;
            end
        end else if (k == KIND_DATA) begin
            if (!row_open) begin
                w.pixel = '0;
                w.last = 1'b0;
                w.error = ERR_OUTSIDE;
                pending_pixels.push_back(w);
            end else begin
                // clamp out-of-range register values
                len = (row_len_reg == 0) ? 1 : row_len_reg;
                if (len > MAX_ROW_BYTES)
                    len = MAX_ROW_BYTES;
                stride = (pixel_dist_reg == 0) ? 1 : pixel_dist_reg;
                if (stride > HIST_DEPTH)
                    stride = HIST_DEPTH;
                i = (row_pos < len) ? row_pos : len - 1;
                slot = i % stride;

                left = (i >= stride) ? left_hist[slot] : '0;
                up = pass_first_row ? '0 : prior_row[i];
                upleft = (i >= stride && !pass_first_row) ? above_left_hist[slot] : '0;

                case (row_filter)
                    FILT_SUB:   base = left;
                    FILT_UP:    base = up;
                    FILT_AVG:   base = BYTE_W'(({1'b0, left} + {1'b0, up}) >> 1);
                    FILT_PAETH: base = paeth_choice(left, up, upleft);
                    default:    base = '0;
                endcase
                val = b + base;

                above_left_hist[slot] = up;
                left_hist[slot] = val;
                prior_row[i] = val;

                w.pixel = val;
                w.error = ERR_NONE;
                w.last = (i + 1 >= len);
                if (w.last) begin
                    row_open = 1'b0;
                    pass_first_row = 1'b0;
                    row_pos = 0;
                end else begin
                    row_pos = i + 1;
                end
                pending_pixels.push_back(w);
            end
        end
    endtask

    task automatic note_mismatch(input bit has_exp, input pixel_word_t e, input pixel_word_t g);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            if (has_exp)
                $display("%0t: word mismatch: expected pixel %02h last %0d error %0d, got pixel %02h last %0d error %0d",
                         $time, e.pixel, e.last, e.error, g.pixel, g.last, g.error);
            else
                $display("%0t: unexpected word: pixel %02h last %0d error %0d",
                         $time, g.pixel, g.last, g.error);
        end
    endtask

    // track register writes and accepted words, compare each output word
    always @(posedge clk or negedge rst_n) begin
        pixel_word_t got;
        pixel_word_t want;
        if (!rst_n) begin
            pending_pixels.delete();
            for (int n = 0; n < HIST_DEPTH; n++) begin
                left_hist[n] = '0;
                above_left_hist[n] = '0;
            end
            row_pos = 0;
            row_filter = FILT_NONE;
            pass_first_row = 1'b1;
            row_open = 1'b0;
            row_len_reg = 1;
            pixel_dist_reg = 1;
            fail_count = 0;
            mismatches <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == REG_ROW_BYTES)
                    row_len_reg = int'(cfg_data[ROW_BYTES_W-1:0]);
                else if (cfg_index == REG_BYTES_PER_PIXEL)
                    pixel_dist_reg = int'(cfg_data[BPP_W-1:0]);
            end
            if (filtered.valid && filtered.ready)
                reconstruct(filtered.kind, filtered.data_byte);
            if (pixels.valid && pixels.ready) begin
                got = {pixels.pixel_byte, pixels.last_of_row, pixels.error};
                if (pending_pixels.size() == 0) begin
                    note_mismatch(1'b0, '0, got);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want)
                        note_mismatch(1'b1, want, got);
                end
            end
            mismatches <= fail_count;
            outstanding <= pending_pixels.size();
        end
    end

endmodule

>>> sim/png_row_unfilter_top_test.sv
// Top of the PNG row unfilter testbench: clock, reset, stimulus, output stalls
// and the verdict. Depends on pru_pkg, pru_if, the block and the checker.
module png_row_unfilter_top_test
    import pru_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 850;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES  = 10;
    localparam int DRAIN_LIMIT  = 100000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_EVERY   = 1500;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 20000000;
    localparam int LONG_ROW_PART = 24;
    localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_ALL_ONES = '1;

    // kind code the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum {STALL_NONE, STALL_HALF, STALL_RARE, STALL_PERIODIC} stall_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     outstanding;

    pru_in_if  filtered();
    pru_out_if pixels();

    png_row_unfilter_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .filtered (filtered),
        .pixels   (pixels)
    );

    png_row_unfilter_checker row_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .filtered   (filtered),
        .pixels     (pixels),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // row position shadow, kept only to avoid reading never-written row bytes
    int row_len_set = 1;
    int shadow_pos = 0;
    bit shadow_open = 1'b0;
    bit shadow_first = 1'b1;
    int written_extent = 0;
    int items_sent = 0;
    int burst_left = 0;

    function automatic int row_len_eff();
        int len;
        len = (row_len_set == 0) ? 1 : row_len_set;
        if (len > DEFAULT_MAX_ROW_BYTES)
            len = DEFAULT_MAX_ROW_BYTES;
        return len;
    endfunction

    function automatic logic [BYTE_W-1:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] open_kind();
        return ($urandom_range(0, 5) == 0) ? KIND_PASS : KIND_ROW;
    endfunction

    function automatic logic [BYTE_W-1:0] random_filter();
        return BYTE_W'($urandom_range(FILT_NONE, FILT_PAETH));
    endfunction

    // follow row position and written extent of the row memory
    task automatic track_word(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
        int len;
        int i;
        if (k == KIND_UNUSED)
            return;
        items_sent++;
        if (k != KIND_DATA) begin
            if (k == KIND_PASS)
                shadow_first = 1'b1;
            if (b >= FILTER_LIMIT) begin
                shadow_open = 1'b0;
            end else begin
                shadow_open = 1'b1;
                shadow_pos = 0;
            end
        end else if (shadow_open) begin
            len = row_len_eff();
            i = (shadow_pos < len) ? shadow_pos : len - 1;
            if (i + 1 > written_extent)
                written_extent = i + 1;
            if (i + 1 >= len) begin
                shadow_open = 1'b0;
                shadow_first = 1'b0;
                shadow_pos = 0;
            end else begin
                shadow_pos = i + 1;
            end
        end
    endtask

    // offer one word in bursts with random gaps, hold until accepted
    task automatic send_word(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                filtered.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        filtered.valid <= 1'b1;
        filtered.kind <= k;
        filtered.data_byte <= b;
        @(posedge clk);
        while (!filtered.ready)
            @(posedge clk);
        track_word(k, b);
    endtask

    // reopen as a pass's first row where the byte above was never written
    task automatic send_data(input logic [BYTE_W-1:0] b);
        int len;
        int i;
        len = row_len_eff();
        i = (shadow_pos < len) ? shadow_pos : len - 1;
        if (shadow_open && !shadow_first && i >= written_extent)
            send_word(KIND_PASS, random_filter());
        send_word(KIND_DATA, b);
    endtask

    task automatic send_row(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] f,
                            input int n);
        send_word(k, f);
        repeat (n) send_data(random_byte());
    endtask

    // write a register once every word in flight has come out
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        filtered.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ROW_BYTES)
            row_len_set = int'(val);
    endtask

    task automatic random_phase(input int phase);
        logic [CFG_DATA_W-1:0] dist_word;
        int                    len;
        int                    rows;
        case ($urandom_range(0, 19))
            0:       len = 0;
            1:       len = 1;
            2:       len = $urandom_range(100, 260);
            default: len = $urandom_range(2, 24);
        endcase
        dist_word = CFG_DATA_W'($urandom);
        case (phase)
            0:       dist_word[BPP_W-1:0] = '0;
            1:       dist_word[BPP_W-1:0] = MAX_BPP;
            2:       dist_word[BPP_W-1:0] = '1;
            default: dist_word[BPP_W-1:0] = BPP_W'($urandom_range(0, 15));
        endcase
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(len));
        write_reg(REG_BYTES_PER_PIXEL, dist_word);
        rows = $urandom_range(3, 8);
        // mostly whole rows, with some broken rows and noise
        repeat (rows) begin
            case ($urandom_range(0, 19))
                0:       send_word(open_kind(), BYTE_W'($urandom_range(FILTER_LIMIT, 255)));
                1:       send_data(random_byte());
                2:       send_word(KIND_UNUSED, random_byte());
                3:       send_row(open_kind(), random_filter(),
                                  $urandom_range(0, row_len_eff() - 1));
                4:       send_row(open_kind(), random_filter(),
                                  row_len_eff() + $urandom_range(1, 3));
                default: send_row(open_kind(), random_filter(), row_len_eff());
            endcase
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int phase;
        int waited;
        int random_start;
        logic [CFG_DATA_W-1:0] dist_word;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_ROW_BYTES;
        cfg_data <= '0;
        filtered.valid <= 1'b0;
        filtered.kind <= KIND_DATA;
        filtered.data_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // error words and the ignored kind
        send_word(KIND_DATA, 8'hFF);
        send_word(KIND_ROW, FILTER_LIMIT);
        send_word(KIND_PASS, 8'hFF);
        send_word(KIND_UNUSED, 8'hA5);

        // one row of each filter type, extremes of the data byte first
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(3));
        write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(1));
        send_word(KIND_PASS, BYTE_W'(FILT_NONE));
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h80);
        send_row(KIND_ROW, BYTE_W'(FILT_SUB), 3);
        send_row(KIND_ROW, BYTE_W'(FILT_UP), 3);
        send_row(KIND_ROW, BYTE_W'(FILT_AVG), 3);
        send_row(KIND_ROW, BYTE_W'(FILT_PAETH), 3);

        // abandon a row with a new filter byte, then shorten the open row
        send_word(KIND_ROW, BYTE_W'(FILT_UP));
        send_data(8'hFF);
        send_row(KIND_ROW, BYTE_W'(FILT_PAETH), 2);
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(1));
        send_data(8'h7F);

        // random phases over a range of settings
        phase = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            random_phase(phase);
            phase++;
        end

        // start a row at the largest length, then part of a following row
        dist_word = CFG_DATA_W'($urandom);
        write_reg(REG_ROW_BYTES, CFG_DATA_W'(ROW_BYTES_ALL_ONES));
        write_reg(REG_BYTES_PER_PIXEL, dist_word);
        send_row(KIND_PASS, random_filter(), LONG_ROW_PART);
        send_row(KIND_ROW, BYTE_W'(FILT_PAETH), LONG_ROW_PART);

        // drain
        filtered.valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (outstanding != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // output stalls: random segments of stall patterns plus long hold-offs
    initial
    begin
        stall_mode_t mode;
        int          seg;
        int          cyc;
        pixels.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        mode = STALL_NONE;
        seg = 0;
        cyc = 0;
        forever begin
            if (cyc % HOLD_EVERY == HOLD_AT) begin
                pixels.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                cyc += HOLD_CYCLES;
            end
            if (seg == 0) begin
                mode = stall_mode_t'($urandom_range(0, 3));
                seg = $urandom_range(20, 200);
            end
            case (mode)
                STALL_NONE:  pixels.ready <= 1'b1;
                STALL_HALF:  pixels.ready <= 1'($urandom_range(0, 1));
                STALL_RARE:  pixels.ready <= ($urandom_range(0, 7) != 0);
                default:     pixels.ready <= (cyc % 5 < 3);
            endcase
            seg--;
            cyc++;
            @(posedge clk);
        end
    end

    // overall limit on the run
    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
